// ===== rtl/core/grlq_pkg.sv =====
// Shared types and constants of the grey relief level quantizer.
package grlq_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_LEVEL_COUNT   = 3'd0;
    localparam t_cfg_idx CFG_NEGATIVE_MODE = 3'd1;
    localparam t_cfg_idx CFG_RELIEF_HEIGHT = 3'd2;
    localparam t_cfg_idx CFG_BASE_HEIGHT   = 3'd3;
    localparam t_cfg_idx CFG_IMAGE_WIDTH   = 3'd4;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT  = 3'd5;

    typedef logic [1:0] t_action;

    localparam t_action ACT_MEASURE = 2'd0;
    localparam t_action ACT_EMIT    = 2'd1;
    localparam t_action ACT_RESTART = 2'd2;

    typedef struct packed {
        t_action    action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  level;
        logic [16:0] height;
        logic        last_pixel;
    } t_pix_out;

    // Shared divider: numerator is left-aligned, only the low "steps" bits are quotient.
    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 11;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV1_STEPS = 5'd19;
    localparam logic [DIV_CNT_W-1:0] DIV2_STEPS = 5'd25;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/core/grlq_if.sv =====
// Handshake channel interfaces for pixel words, result words and register writes.
interface grlq_pix_if;
    import grlq_pkg::*;
    logic    valid;
    logic    ready;
    t_pix_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grlq_res_if;
    import grlq_pkg::*;
    logic     valid;
    logic     ready;
    t_pix_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grlq_cfg_if;
    import grlq_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/grlq_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module grlq_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  grlq_pkg::t_div_req                 i_req,
    output grlq_pkg::t_div_stat                o_stat,
    output logic [grlq_pkg::DIV_NUM_W-1:0]     o_quot
);
    import grlq_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] trial;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        if (trial[DIV_DEN_W+1]) begin
            n_rem = shifted[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_NUM_W-2:0], 1'b0};
        end else begin
            n_rem = trial[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_NUM_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

// ===== rtl/core/grey_relief_level_quantizer.sv =====
// Grey relief level quantizer: measure/emit sequencer around one multiplier and one divider.
// A measure, restart or ignored word leaves the sequencer idle, and the block is ready again next cycle.
// An emit word passes through the multiplier and two serial divider passes of 19 and 25 steps
// before its result word is registered (a zero maximum skips the first division); the next
// word is accepted once the sequencer is back in idle. The output register lets it in while a result waits.
// Reset is synchronous and active low: registers take their defaults, max and column clear.
module grey_relief_level_quantizer #(
    parameter int MAX_DIM = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    grlq_pix_if.sink   i_pix,
    grlq_res_if.source o_res,
    grlq_cfg_if.sink   i_cfg
);
    import grlq_pkg::*;

    // Dimensions are clamped to what the 12-bit position fields can hold.
    localparam int          DIM_CAP = (MAX_DIM < 4096) ? MAX_DIM : 4096;
    localparam logic [12:0] CAP13   = 13'(DIM_CAP);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_ST1  = 3'd2;
    localparam logic [2:0] S_WT1  = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_ST2  = 3'd5;
    localparam logic [2:0] S_WT2  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    function automatic logic [12:0] eff_dim(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > CAP13) begin
            r = CAP13;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [7:0]  r_lc;
    logic        r_neg;
    logic [15:0] r_rel;
    logic [15:0] r_base;
    logic [12:0] r_w;
    logic [12:0] r_h;

    // Running state.
    logic [2:0]  r_state;
    logic [9:0]  r_max;
    logic [11:0] r_col;
    logic [11:0] r_row;

    // Work registers of the word in flight.
    logic [9:0]  r_sum;
    logic [25:0] r_prod;
    logic [7:0]  r_lvl;
    logic [11:0] r_pcol;
    logic [11:0] r_prow;
    logic        r_plast;

    // Output register.
    logic        r_ov;
    t_pix_out    r_out;

    logic [7:0]  lc_eff;
    logic [7:0]  lm1;
    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic [12:0] wm1_full;
    logic [12:0] hm1_full;
    logic [11:0] wm1;
    logic [11:0] hm1;
    logic [9:0]  sum;
    logic        row_end;
    logic        in_acc;
    logic        out_free;
    logic [15:0] mul_a;
    logic [9:0]  mul_b;
    logic [25:0] prod;
    logic [18:0] num1;
    logic [24:0] num2;
    logic [7:0]  q_sat;
    logic [7:0]  lvl_new;
    t_div_req    div_req;
    t_div_stat   div_stat;
    logic [DIV_NUM_W-1:0] div_quot;

    always_comb begin
        lc_eff   = (r_lc < 8'd2) ? 8'd2 : r_lc;
        lm1      = lc_eff - 8'd1;
        w_eff    = eff_dim(r_w);
        h_eff    = eff_dim(r_h);
        wm1_full = w_eff - 13'd1;
        hm1_full = h_eff - 13'd1;
        wm1      = wm1_full[11:0];
        hm1      = hm1_full[11:0];
        sum      = 10'(i_pix.data.red) + 10'(i_pix.data.green) + 10'(i_pix.data.blue);
        row_end  = (r_col >= wm1);
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign out_free    = !r_ov || o_res.ready;

    // One multiplier serves both products: (L-1)*sum, then relief*level.
    always_comb begin
        if (r_state == S_MUL2) begin
            mul_a = r_rel;
            mul_b = {2'b00, r_lvl};
        end else begin
            mul_a = {8'd0, lm1};
            mul_b = r_sum;
        end
        prod = 26'(mul_a) * 26'(mul_b);
    end

    // Numerators carry the half-up rounding term; denominators are doubled to match.
    always_comb begin
        num1 = {r_prod[17:0], 1'b0} + 19'(r_max);
        num2 = {r_prod[23:0], 1'b0} + 25'(lc_eff);
        div_req.start = (r_state == S_ST1) || (r_state == S_ST2);
        if (r_state == S_ST2) begin
            div_req.steps = DIV2_STEPS;
            div_req.num   = num2;
            div_req.den   = {2'b00, lc_eff, 1'b0};
        end else begin
            div_req.steps = DIV1_STEPS;
            div_req.num   = {num1, 6'd0};
            div_req.den   = {r_max, 1'b0};
        end
    end

    // Quotient of the level division saturates at L-1, then optional inversion.
    always_comb begin
        q_sat   = (div_quot > DIV_NUM_W'(lm1)) ? lm1 : div_quot[7:0];
        lvl_new = r_neg ? (lm1 - q_sat) : q_sat;
    end

    grlq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc   <= 8'd20;
            r_neg  <= 1'b1;
            r_rel  <= 16'd256;
            r_base <= 16'd51;
            r_w    <= 13'd4096;
            r_h    <= 13'd4096;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_LEVEL_COUNT:   r_lc   <= i_cfg.data[7:0];
                CFG_NEGATIVE_MODE: r_neg  <= i_cfg.data[0];
                CFG_RELIEF_HEIGHT: r_rel  <= i_cfg.data;
                CFG_BASE_HEIGHT:   r_base <= i_cfg.data;
                CFG_IMAGE_WIDTH:   r_w    <= i_cfg.data[12:0];
                CFG_IMAGE_HEIGHT:  r_h    <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // Sequencer, maximum and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= '0;
            r_col   <= '0;
            r_row   <= 12'(CAP13 - 13'd1);
            r_ov    <= 1'b0;
        end else begin
            // A new result word may take the slot in the same cycle the old one leaves.
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_pix.data.action)
                            ACT_MEASURE: begin
                                if (sum > r_max) begin
                                    r_max <= sum;
                                end
                            end
                            ACT_RESTART: begin
                                r_max <= '0;
                                r_col <= '0;
                                r_row <= hm1;
                            end
                            ACT_EMIT: begin
                                r_state <= S_MUL1;
                                if (row_end) begin
                                    r_col <= '0;
                                    r_row <= (r_row == 12'd0) ? hm1 : (r_row - 12'd1);
                                end else begin
                                    r_col <= r_col + 12'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL1: begin
                    // With no measured maximum the level is zero before inversion.
                    r_state <= (r_max == 10'd0) ? S_MUL2 : S_ST1;
                end
                S_ST1:  r_state <= S_WT1;
                S_WT1: begin
                    if (div_stat.done) begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: r_state <= S_ST2;
                S_ST2:  r_state <= S_WT2;
                S_WT2: begin
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the word in flight.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum   <= sum;
            r_pcol  <= r_col;
            r_prow  <= r_row;
            r_plast <= row_end && (r_row == 12'd0);
        end
        if (r_state == S_MUL1 || r_state == S_MUL2) begin
            r_prod <= prod;
        end
        if (r_state == S_MUL1 && r_max == 10'd0) begin
            r_lvl <= r_neg ? lm1 : 8'd0;
        end else if (r_state == S_WT1 && div_stat.done) begin
            r_lvl <= lvl_new;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.column     <= r_pcol;
            r_out.row        <= r_prow;
            r_out.level      <= r_lvl;
            r_out.height     <= 17'(r_base) + 17'(div_quot[15:0]);
            r_out.last_pixel <= r_plast;
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_emit_enters_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_pix.data.action == ACT_EMIT) |=> (r_state == S_MUL1))
        else $error("emit word did not start the sequence");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL2) |-> (r_lvl <= lm1))
        else $error("level beyond level count");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && !o_res.ready) |=> (r_state == S_OUT && r_ov))
        else $error("pending result word overwritten");

endmodule
